/* hdl/lpa_pkg.sv */
// Shared types, widths, codes and constants of the line pair angle evaluator.
package lpa_pkg;

    localparam int VEC_W  = 31;
    localparam int PROD_W = 62;
    localparam int SUM_W  = 63;
    localparam int CX_W   = 64;
    localparam int Z_W    = 34;
    localparam int ERR_W  = 40;
    localparam int DIFF_W = 41;
    localparam int NUM_W  = 79;
    localparam int DEN_W  = 62;
    localparam int QUO_W  = 49;
    localparam int VAL_W  = 48;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] FUNC_ERR    = 4'd0;
    localparam logic [3:0] FUNC_DER_LO = 4'd1;
    localparam logic [3:0] FUNC_DER_HI = 4'd8;
    localparam logic [3:0] FUNC_STEP   = 4'd9;

    localparam logic REG_TARGET   = 1'b0;
    localparam logic REG_MAX_STEP = 1'b1;

    localparam logic signed [31:0] TARGET_RESET   = 32'sd421657428;
    localparam logic [30:0]        MAX_STEP_RESET = 31'd46850825;

    localparam logic signed [Z_W-1:0] ANG_HALF_PI = 34'sd1686629713;

    localparam logic [QUO_W-1:0] POS_LIM = 49'd140737488355327;
    localparam logic [QUO_W-1:0] NEG_LIM = 49'd140737488355328;
    localparam logic [VAL_W-1:0] ONE_Q32 = 48'h0001_0000_0000;

    localparam logic [31:0] ATAN_LOW [10] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD
    };

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } lpa_status_t;

    // classified request as held in the queue
    typedef struct packed {
        logic [3:0]              func;
        logic signed [VEC_W-1:0] px;
        logic signed [VEC_W-1:0] py;
        logic signed [VEC_W-1:0] rx;
        logic signed [VEC_W-1:0] ry;
        logic [1:0]              t1;
        logic [1:0]              t2;
        logic                    zero_len;
        logic signed [31:0]      last_error;
    } lpa_item_t;

    // sideband carried along the CORDIC pipe
    typedef struct packed {
        logic [3:0]         func;
        logic               zero_len;
        logic               m_zero;
        logic               neg;
        logic [VEC_W-1:0]   mag;
        logic [1:0]         t;
        logic [DEN_W-1:0]   len2;
        logic signed [31:0] last_error;
    } lpa_side_t;

    // sideband carried along the divider pipe
    typedef struct packed {
        logic [3:0]              func;
        logic                    zero_len;
        logic                    m_zero;
        logic                    neg;
        logic                    big;
        logic signed [ERR_W-1:0] err;
    } lpa_fin_t;

    function automatic logic [31:0] atan_step(input int i);
        logic [31:0] r;
        if (i < 10)
        begin
            r = ATAN_LOW[4'(i)];
        end
        else if (i < 30)
        begin
            r = 32'((64'd1 << (30 - i)) - 64'd1);
        end
        else
        begin
            r = '0;
        end
        return r;
    endfunction

endpackage

/* hdl/lpa_in_if.sv */
// Input request channel of the line pair angle evaluator.
interface lpa_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  func;
    logic [31:0] first_start_x;
    logic [31:0] first_start_y;
    logic [31:0] first_end_x;
    logic [31:0] first_end_y;
    logic [31:0] second_start_x;
    logic [31:0] second_start_y;
    logic [31:0] second_end_x;
    logic [31:0] second_end_y;
    logic [31:0] last_error;

    modport source (
        output valid, func, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y, last_error,
        input  ready
    );
    modport sink (
        input  valid, func, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y, last_error,
        output ready
    );
endinterface

/* hdl/lpa_out_if.sv */
// Result channel of the line pair angle evaluator.
interface lpa_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] value;
    logic [1:0]  status;

    modport source (output valid, value, status, input ready);
    modport sink (input valid, value, status, output ready);
endinterface

/* hdl/line_pair_angle_constraint_eval.sv */
// Line pair angle constraint evaluator, top level.
// Stages: products, CORDIC entry and steps, error terms, divider stages, result register.
// Throughput: one request per cycle when not stalled; CORDIC and 49-stage divider pipelined.
// A stalled result register holds the whole back end; the 4-entry queue absorbs the front.
// Reset clears all valid flags and loads the two configuration registers; no memory clearing.
module line_pair_angle_constraint_eval
    import lpa_pkg::*;
#(
    parameter int CORDIC_STEPS = 32,
    parameter int COORD_BITS   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    lpa_in_if.sink      in_ch,
    lpa_out_if.source   out_ch
);

    logic signed [31:0] target_reg;
    logic [30:0]        max_step_reg;
    logic               q_full, push, pop, q_valid;
    lpa_item_t          push_item, q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= TARGET_RESET;
            max_step_reg <= MAX_STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET:   target_reg   <= cfg_data;
                REG_MAX_STEP: max_step_reg <= cfg_data[30:0];
                default:      ;
            endcase
        end
    end

    lpa_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .in_ch  (in_ch),
        .q_full (q_full),
        .push   (push),
        .item   (push_item)
    );

    lpa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    lpa_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .target_angle    (target_reg),
        .max_step_change (max_step_reg),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .pop             (pop),
        .out_ch          (out_ch)
    );

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> q_valid)
        else $error("queue full but reports no data");

    a_stall_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |-> !pop)
        else $error("back end drained queue while result stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.status == ST_OK || out_ch.status == ST_ZERO
                          || out_ch.status == ST_SAT))
        else $error("undefined status code");

endmodule

/* hdl/lpa_front.sv */
// Front end: line vectors, range reduction and zero length check.
module lpa_front
    import lpa_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    lpa_in_if.sink    in_ch,
    input  logic      q_full,
    output logic      push,
    output lpa_item_t item
);

    logic signed [32:0] px, py, rx, ry;
    logic [1:0]         t1, t2;

    function automatic logic signed [32:0] coord_diff(input logic [31:0] e,
                                                      input logic [31:0] s);
        logic signed [COORD_BITS-1:0] es;
        logic signed [COORD_BITS-1:0] ss;
        es = e[COORD_BITS-1:0];
        ss = s[COORD_BITS-1:0];
        return 33'(es) - 33'(ss);
    endfunction

    function automatic logic in_lim(input logic signed [32:0] v);
        return (v > -33'sd1073741824) && (v < 33'sd1073741824);
    endfunction

    function automatic logic [1:0] shrink_count(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic [1:0] c;
        if (in_lim(a) && in_lim(b))
        begin
            c = 2'd0;
        end
        else if (in_lim(a >>> 1) && in_lim(b >>> 1))
        begin
            c = 2'd1;
        end
        else if (in_lim(a >>> 2) && in_lim(b >>> 2))
        begin
            c = 2'd2;
        end
        else
        begin
            c = 2'd3;
        end
        return c;
    endfunction

    assign px = coord_diff(in_ch.first_end_x, in_ch.first_start_x);
    assign py = coord_diff(in_ch.first_end_y, in_ch.first_start_y);
    assign rx = coord_diff(in_ch.second_end_x, in_ch.second_start_x);
    assign ry = coord_diff(in_ch.second_end_y, in_ch.second_start_y);
    assign t1 = shrink_count(px, py);
    assign t2 = shrink_count(rx, ry);

    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    always_comb
    begin
        item.func       = in_ch.func;
        item.px         = VEC_W'(px >>> t1);
        item.py         = VEC_W'(py >>> t1);
        item.rx         = VEC_W'(rx >>> t2);
        item.ry         = VEC_W'(ry >>> t2);
        item.t1         = t1;
        item.t2         = t2;
        item.zero_len   = ((px == '0) && (py == '0)) || ((rx == '0) && (ry == '0));
        item.last_error = in_ch.last_error;
    end

endmodule

/* hdl/lpa_queue.sv */
// Short request queue between front end and back end.
module lpa_queue
    import lpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  lpa_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      q_valid,
    output lpa_item_t q_item
);

    lpa_item_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hdl/lpa_back.sv */
// Back end: products, CORDIC angle, error terms, pipelined divider, result register.
module lpa_back
    import lpa_pkg::*;
#(
    parameter int CORDIC_STEPS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] target_angle,
    input  logic [30:0]        max_step_change,
    input  logic               q_valid,
    input  lpa_item_t          q_item,
    output logic               pop,
    lpa_out_if.source          out_ch
);

    logic en;

    // stage 1: products
    logic                     s1_v_reg;
    logic signed [PROD_W-1:0] pxrx_reg, pyry_reg, pxry_reg, pyrx_reg, aa_reg, bb_reg;
    logic signed [31:0]       comp_reg;
    logic [3:0]               s1_func_reg;
    logic                     s1_zero_reg;
    logic [1:0]               s1_t_reg;
    logic signed [31:0]       s1_last_reg;
    logic signed [VEC_W-1:0]  la, lb;
    logic signed [31:0]       comp_sel;

    // CORDIC pipe
    logic signed [CX_W-1:0] cx_reg [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] cy_reg [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  cz_reg [CORDIC_STEPS+1];
    lpa_side_t              cs_reg [CORDIC_STEPS+1];
    logic                   cv_reg [CORDIC_STEPS+1];

    logic signed [SUM_W-1:0] dot, crs;
    logic signed [CX_W-1:0]  acrs;
    logic signed [31:0]      comp_m;
    lpa_side_t               side0;

    // error stages
    logic                     e1_v_reg, e2_v_reg;
    lpa_side_t                e1_side_reg, e2_side_reg;
    logic signed [ERR_W-1:0]  e1_err_reg, e2_err_reg;
    logic [DIFF_W-1:0]        e2_d_reg;
    logic                     e2_big_reg;
    logic signed [ERR_W-1:0]  err_c;
    logic signed [DIFF_W-1:0] diff_c;
    logic [DIFF_W-1:0]        d_c;
    logic [34:0]              mx;
    logic [NUM_W-1:0]         num_c;
    logic [DEN_W-1:0]         den_c;
    logic [5:0]               sh_c;
    lpa_fin_t                 fin0;

    // divider pipe
    logic [DEN_W-1:0] dr_reg [QUO_W+1];
    logic [DEN_W-1:0] dd_reg [QUO_W+1];
    logic [QUO_W-1:0] dn_reg [QUO_W+1];
    logic [QUO_W-1:0] dq_reg [QUO_W+1];
    lpa_fin_t         df_reg [QUO_W+1];
    logic             dv_reg [QUO_W+1];

    // result
    logic              out_valid_reg;
    logic [VAL_W-1:0]  value_reg, value_c;
    lpa_status_t       status_reg, status_c;
    lpa_fin_t          fl;
    logic [QUO_W-1:0]  fq, lim, mag_q;

    assign en  = !out_valid_reg || out_ch.ready;
    assign pop = en && q_valid;

    // stage 1
    always_comb
    begin
        if (q_item.func <= 4'd4)
        begin
            la = q_item.px;
            lb = q_item.py;
        end
        else
        begin
            la = q_item.rx;
            lb = q_item.ry;
        end
        case (q_item.func)
            4'd1:    comp_sel = 32'(q_item.py);
            4'd2:    comp_sel = -32'(q_item.px);
            4'd3:    comp_sel = -32'(q_item.py);
            4'd4:    comp_sel = 32'(q_item.px);
            4'd5:    comp_sel = -32'(q_item.ry);
            4'd6:    comp_sel = 32'(q_item.rx);
            4'd7:    comp_sel = 32'(q_item.ry);
            4'd8:    comp_sel = -32'(q_item.rx);
            default: comp_sel = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxrx_reg    <= PROD_W'(q_item.px) * PROD_W'(q_item.rx);
            pyry_reg    <= PROD_W'(q_item.py) * PROD_W'(q_item.ry);
            pxry_reg    <= PROD_W'(q_item.px) * PROD_W'(q_item.ry);
            pyrx_reg    <= PROD_W'(q_item.py) * PROD_W'(q_item.rx);
            aa_reg      <= PROD_W'(la) * PROD_W'(la);
            bb_reg      <= PROD_W'(lb) * PROD_W'(lb);
            comp_reg    <= comp_sel;
            s1_func_reg <= q_item.func;
            s1_zero_reg <= q_item.zero_len;
            s1_t_reg    <= (q_item.func <= 4'd4) ? q_item.t1 : q_item.t2;
            s1_last_reg <= q_item.last_error;
        end
    end

    // sums and CORDIC entry; m = -crs
    always_comb
    begin
        dot    = SUM_W'(pxrx_reg) + SUM_W'(pyry_reg);
        crs    = SUM_W'(pxry_reg) - SUM_W'(pyrx_reg);
        acrs   = (crs < 0) ? -CX_W'(crs) : CX_W'(crs);
        comp_m = (crs > 0) ? -comp_reg : comp_reg;
        side0.func       = s1_func_reg;
        side0.zero_len   = s1_zero_reg;
        side0.m_zero     = (crs == '0);
        side0.neg        = comp_m[31];
        side0.mag        = comp_m[31] ? VEC_W'(-comp_m) : VEC_W'(comp_m);
        side0.t          = s1_t_reg;
        side0.len2       = DEN_W'(aa_reg + bb_reg);
        side0.last_error = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            cv_reg[0] <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dot < 0)
            begin
                cx_reg[0] <= acrs;
                cy_reg[0] <= -CX_W'(dot);
                cz_reg[0] <= ANG_HALF_PI;
            end
            else
            begin
                cx_reg[0] <= CX_W'(dot);
                cy_reg[0] <= acrs;
                cz_reg[0] <= '0;
            end
            cs_reg[0] <= side0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        logic signed [CX_W-1:0] xs, ys;
        logic signed [Z_W-1:0]  at;

        assign xs = cx_reg[i] >>> i;
        assign ys = cy_reg[i] >>> i;
        assign at = $signed({2'b00, atan_step(i)});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cy_reg[i] > 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] + ys;
                    cy_reg[i+1] <= cy_reg[i] - xs;
                    cz_reg[i+1] <= cz_reg[i] + at;
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - ys;
                    cy_reg[i+1] <= cy_reg[i] + xs;
                    cz_reg[i+1] <= cz_reg[i] - at;
                end
                cs_reg[i+1] <= cs_reg[i];
            end
        end
    end

    // error, step difference, divider operands
    always_comb
    begin
        err_c  = $signed({{4{cz_reg[CORDIC_STEPS][Z_W-1]}}, cz_reg[CORDIC_STEPS], 2'b00})
               - $signed({{4{target_angle[31]}}, target_angle, 4'b0000});
        diff_c = $signed({{5{e1_side_reg.last_error[31]}}, e1_side_reg.last_error, 4'b0000})
               - DIFF_W'(e1_err_reg);
        d_c    = diff_c[DIFF_W-1] ? DIFF_W'(-diff_c) : DIFF_W'(diff_c);
        mx     = {max_step_change, 4'b0000};
        sh_c   = 6'd48 - 6'(e2_side_reg.t);
        if (e2_side_reg.func == FUNC_STEP)
        begin
            num_c = NUM_W'(mx) << 32;
            den_c = DEN_W'(e2_d_reg);
        end
        else
        begin
            num_c = NUM_W'(e2_side_reg.mag) << sh_c;
            den_c = e2_side_reg.len2;
        end
        fin0.func     = e2_side_reg.func;
        fin0.zero_len = e2_side_reg.zero_len;
        fin0.m_zero   = e2_side_reg.m_zero;
        fin0.neg      = e2_side_reg.neg;
        fin0.big      = e2_big_reg;
        fin0.err      = e2_err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg  <= 1'b0;
            e2_v_reg  <= 1'b0;
            dv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            e1_v_reg  <= cv_reg[CORDIC_STEPS];
            e2_v_reg  <= e1_v_reg;
            dv_reg[0] <= e2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_side_reg <= cs_reg[CORDIC_STEPS];
            e1_err_reg  <= err_c;
            e2_side_reg <= e1_side_reg;
            e2_err_reg  <= e1_err_reg;
            e2_d_reg    <= d_c;
            e2_big_reg  <= (d_c > DIFF_W'(mx));
            dr_reg[0]   <= DEN_W'(num_c[NUM_W-1:QUO_W]);
            dn_reg[0]   <= num_c[QUO_W-1:0];
            dd_reg[0]   <= den_c;
            dq_reg[0]   <= '0;
            df_reg[0]   <= fin0;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        logic [DEN_W:0] rs;
        logic           ge;

        assign rs = {dr_reg[j], dn_reg[j][QUO_W-1-j]};
        assign ge = (rs >= {1'b0, dd_reg[j]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[j+1] <= dv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dr_reg[j+1] <= ge ? DEN_W'(rs - {1'b0, dd_reg[j]}) : DEN_W'(rs);
                dn_reg[j+1] <= dn_reg[j];
                dd_reg[j+1] <= dd_reg[j];
                dq_reg[j+1] <= {dq_reg[j][QUO_W-2:0], ge};
                df_reg[j+1] <= df_reg[j];
            end
        end
    end

    // result selection
    always_comb
    begin
        fl      = df_reg[QUO_W];
        fq      = dq_reg[QUO_W];
        lim     = fl.neg ? NEG_LIM : POS_LIM;
        mag_q   = (fq > lim) ? lim : fq;
        value_c = '0;
        status_c = ST_OK;
        case (fl.func)
            FUNC_ERR:
            begin
                if (fl.zero_len)
                begin
                    status_c = ST_ZERO;
                end
                else
                begin
                    value_c = VAL_W'(fl.err);
                end
            end
            FUNC_STEP:
            begin
                if (fl.zero_len)
                begin
                    status_c = ST_ZERO;
                end
                else
                begin
                    value_c = fl.big ? VAL_W'(fq) : ONE_Q32;
                end
            end
            default:
            begin
                if ((fl.func >= FUNC_DER_LO) && (fl.func <= FUNC_DER_HI))
                begin
                    if (fl.m_zero)
                    begin
                        status_c = ST_ZERO;
                    end
                    else
                    begin
                        value_c  = fl.neg ? VAL_W'(-mag_q) : VAL_W'(mag_q);
                        status_c = (fq > lim) ? ST_SAT : ST_OK;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg  <= value_c;
            status_reg <= status_c;
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.value  = value_reg;
    assign out_ch.status = status_reg;

endmodule
